FILE: hdl/qpv_pkg.sv
// Package for the quadrature position/velocity decoder.
// Holds command codes, the step table and the result struct; no dependencies.
package qpv_pkg;

  localparam int unsigned CntW = 32;
  localparam int unsigned TickW = 4;

  localparam logic [TickW-1:0] AccelEveryRst = TickW'(3);

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_INDEX  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STEP_ZERO = 2'd0,
    STEP_INC  = 2'd1,
    STEP_DEC  = 2'd2,
    STEP_BAD  = 2'd3
  } step_e;

  // Step by [new phase][old phase], phase = {chan_b, chan_a}.
  localparam step_e StepTable [4][4] = '{
    '{STEP_ZERO, STEP_DEC,  STEP_INC,  STEP_BAD },
    '{STEP_INC,  STEP_ZERO, STEP_BAD,  STEP_DEC },
    '{STEP_DEC,  STEP_BAD,  STEP_ZERO, STEP_INC },
    '{STEP_BAD,  STEP_INC,  STEP_DEC,  STEP_ZERO}
  };

  typedef struct packed {
    logic signed [CntW-1:0] position;
    logic signed [CntW-1:0] velocity;
    logic signed [CntW-1:0] acceleration;
    logic signed [CntW-1:0] rev_count;
    logic                   bad_transition;
  } res_t;

endpackage

FILE: hdl/qpv_in_if.sv
// Request channel of the quadrature decoder: valid/ready plus command and pins.
// Depends on nothing.
interface qpv_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       chan_a;
  logic       chan_b;

  modport source (output valid, command, chan_a, chan_b, input ready);
  modport sink   (input valid, command, chan_a, chan_b, output ready);
endinterface

FILE: hdl/qpv_out_if.sv
// Result channel of the quadrature decoder: valid/ready plus the result fields.
// Depends on nothing.
interface qpv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [31:0] acceleration;
  logic signed [31:0] rev_count;
  logic               bad_transition;

  modport source (output valid, position, velocity, acceleration, rev_count,
                  bad_transition, input ready);
  modport sink   (input valid, position, velocity, acceleration, rev_count,
                  bad_transition, output ready);
endinterface

FILE: hdl/qpv_core.sv
// Decoder state and its combinational next-state update: phase, position, velocity,
// acceleration and revolution registers. Uses qpv_pkg.
module qpv_core import qpv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [TickW-1:0] cfg_wdata_i,
  input  logic             accept_i,
  input  logic [1:0]       cmd_i,
  input  logic             chan_a_i,
  input  logic             chan_b_i,
  output res_t             res_o
);

  logic [TickW-1:0] accel_every_q;
  logic [1:0]       phase_q, phase_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]  pos_tick_q, pos_tick_d;
  logic [CntW-1:0]  vel_q, vel_d;
  logic [CntW-1:0]  vel_accel_q, vel_accel_d;
  logic [CntW-1:0]  accel_q, accel_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [CntW-1:0]  pos_index_q, pos_index_d;
  logic [CntW-1:0]  rev_q, rev_d;
  logic             bad_d;

  always_comb begin
    logic [1:0]       phase;
    logic [TickW-1:0] tick_inc;
    step_e            step;
    phase       = {chan_b_i, chan_a_i};
    step        = StepTable[phase][phase_q];
    tick_inc    = tick_q + TickW'(1);
    phase_d     = phase_q;
    pos_d       = pos_q;
    pos_tick_d  = pos_tick_q;
    vel_d       = vel_q;
    vel_accel_d = vel_accel_q;
    accel_d     = accel_q;
    tick_d      = tick_q;
    pos_index_d = pos_index_q;
    rev_d       = rev_q;
    bad_d       = 1'b0;
    unique case (cmd_i)
      CMD_SAMPLE: begin
        phase_d = phase;
        unique case (step)
          STEP_INC:  pos_d = pos_q + CntW'(1);
          STEP_DEC:  pos_d = pos_q - CntW'(1);
          STEP_BAD:  bad_d = 1'b1;
          default:   ;
        endcase
      end
      CMD_TICK: begin
        vel_d      = pos_q - pos_tick_q;
        pos_tick_d = pos_q;
        tick_d     = tick_inc;
        if (tick_inc >= accel_every_q) begin
          accel_d     = vel_d - vel_accel_q;
          vel_accel_d = vel_d;
          tick_d      = '0;
        end
      end
      CMD_INDEX: begin
        rev_d       = pos_q - pos_index_q;
        pos_index_d = pos_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_every_q <= AccelEveryRst;
    end else if (cfg_we_i) begin
      accel_every_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      pos_q       <= '0;
      pos_tick_q  <= '0;
      vel_q       <= '0;
      vel_accel_q <= '0;
      accel_q     <= '0;
      tick_q      <= '0;
      pos_index_q <= '0;
      rev_q       <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      pos_tick_q  <= pos_tick_d;
      vel_q       <= vel_d;
      vel_accel_q <= vel_accel_d;
      accel_q     <= accel_d;
      tick_q      <= tick_d;
      pos_index_q <= pos_index_d;
      rev_q       <= rev_d;
    end
  end

  // Result carries the state after this request.
  assign res_o.position       = pos_d;
  assign res_o.velocity       = vel_d;
  assign res_o.acceleration   = accel_d;
  assign res_o.rev_count      = rev_d;
  assign res_o.bad_transition = bad_d;

  // Only pin samples move the position.
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (cmd_i != CMD_SAMPLE) |=> pos_q == $past(pos_q))
    else $error("position moved on a non-sample request");

  // Index latches the span since the previous index.
  a_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (cmd_i == CMD_INDEX)
      |=> (rev_q == $past(pos_q - pos_index_q)) && (pos_index_q == pos_q))
    else $error("rev_count latch wrong");

  // Tick records the position it measured from.
  a_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (cmd_i == CMD_TICK) |=> pos_tick_q == pos_q)
    else $error("tick reference not updated");

endmodule

FILE: hdl/qpv_skid.sv
// Two-entry output stage: result register plus skid register, so the
// request side sees no combinational path from result ready. Uses qpv_pkg.
module qpv_skid import qpv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic out_valid_q;
  logic skid_valid_q;
  res_t out_q;
  res_t skid_q;
  logic push;
  logic drain;

  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && in_ready_o;
  assign drain       = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (drain) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      out_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (push) begin
      skid_q <= in_data_i;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result with the output register empty");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && out_valid_q && !out_ready_i |=> skid_valid_q && out_valid_q)
    else $error("stalled request not caught in skid");

  a_skid_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_ready_i |=> out_q == $past(skid_q))
    else $error("skid result not forwarded in order");

endmodule

FILE: hdl/quadrature_position_velocity_top.sv
// Top level of the x4 quadrature position/velocity decoder.
// Uses qpv_pkg, qpv_in_if, qpv_out_if, qpv_core and qpv_skid.
//
// Usage
//  - in_i carries requests: command 0 is a pin sample (chan_a/chan_b
//    levels), 1 a sample tick, 2 an index pulse; 3 changes nothing.
//  - Each accepted request yields exactly one result on out_o: the position,
//    velocity, acceleration and rev_count after that request, plus
//    bad_transition when a pin sample flipped both channels at once (the
//    position then holds, but the new phase is still taken).
//  - cfg_we_i/cfg_wdata_i write accel_every (ticks per acceleration update,
//    0 behaves as 1); write only while no result is outstanding.
// Timing
//  - The table lookup and up to two chained 32-bit subtracts sit between the
//    state registers and the output register; the block takes one request
//    per cycle while the skid register is empty.
//  - A skid register behind the output register keeps in_i.ready free of any
//    path from out_o.ready; with the receiver stalled, one more request is
//    taken, then ready drops until the skid drains.
// Reset
//  - rst_ni clears all counters, the phase and both output stages, and sets
//    accel_every to 3. No clearing pass.
module quadrature_position_velocity_top import qpv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [TickW-1:0] cfg_wdata_i,
  qpv_in_if.sink           in_i,
  qpv_out_if.source        out_o
);

  logic accept;
  logic in_ready;
  res_t res;
  res_t res_q;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // State update; the core's outputs already hold the post-request values.
  qpv_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .cmd_i       (in_i.command),
    .chan_a_i    (in_i.chan_a),
    .chan_b_i    (in_i.chan_b),
    .res_o       (res)
  );

  // Output register and skid.
  qpv_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_data_i   (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (res_q)
  );

  assign out_o.position       = res_q.position;
  assign out_o.velocity       = res_q.velocity;
  assign out_o.acceleration   = res_q.acceleration;
  assign out_o.rev_count      = res_q.rev_count;
  assign out_o.bad_transition = res_q.bad_transition;

endmodule

FILE: sim/quadrature_position_velocity_top_test.sv
// Self-checking bench for quadrature_position_velocity_top: drives requests and
// checks every result against an in-bench decoder. Needs qpv_pkg and both channel
// interfaces from the RTL.
module quadrature_position_velocity_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qpv_pkg::*;

  localparam int unsigned HalfPeriod    = 10;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned WatchdogLimit = 1000;
  // Settling time after the last result is back, before the next step.
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned LongHold      = 80;
  // Command 3 has no member in cmd_e; the block leaves everything alone.
  localparam logic [1:0]  CmdUnused     = 2'd3;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [TickW-1:0] cfg_wdata_i;

  qpv_in_if  req_if ();
  qpv_out_if res_if ();

  quadrature_position_velocity_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (res_if)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Decoder state as the bench sees it, advanced at each accepted request.
  // ---------------------------------------------------------------------------
  logic [1:0]       phase_m;
  logic [CntW-1:0]  pos_m, pos_tick_m, vel_m, vel_accel_m, accel_m;
  logic [CntW-1:0]  pos_index_m, rev_m;
  logic [TickW-1:0] ticks_m;
  logic [TickW-1:0] accel_every_m;

  res_t readings_q [$];   // predicted readings, oldest first

  int unsigned error_count   = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen  = 0;
  int unsigned flips_seen    = 0;
  int unsigned accel_updates = 0;

  // Stimulus-side knobs, shared with the receiver process.
  logic [1:0]  drive_phase  = 2'b00;  // last pin sample sent as {b, a}
  bit          tx_idle_en   = 1'b1;
  bit          rx_idle_en   = 1'b1;
  int unsigned rx_hold_len  = 0;      // one-off long stall for the receiver

  // Gray position of a phase; the map is its own inverse.
  function automatic logic [1:0] gray_of(input logic [1:0] v);
    return {v[1], v[1] ^ v[0]};
  endfunction

  // x4 decode: one step forward along 00-01-11-10 counts up, one back counts
  // down, both channels changing together cannot be resolved.
  function automatic step_e decode_step(input logic [1:0] now, input logic [1:0] was);
    logic [1:0] g_next;
    g_next = gray_of(was) + 2'd1;
    if (now == was) return STEP_ZERO;
    if ((now ^ was) == 2'b11) return STEP_BAD;
    if (gray_of(now) == g_next) return STEP_INC;
    return STEP_DEC;
  endfunction

  function automatic res_t advance_decoder(input logic [1:0] cmd, input logic a,
                                           input logic b);
    res_t       r;
    logic [1:0] ph;
    r.bad_transition = 1'b0;
    case (cmd)
      CMD_SAMPLE: begin
        ph = {b, a};
        case (decode_step(ph, phase_m))
          STEP_INC: pos_m = pos_m + 1;
          STEP_DEC: pos_m = pos_m - 1;
          STEP_BAD: begin
            // position holds, but the new phase is still taken
            r.bad_transition = 1'b1;
            flips_seen++;
          end
          default: ;
        endcase
        phase_m = ph;
      end
      CMD_TICK: begin
        vel_m      = pos_m - pos_tick_m;
        pos_tick_m = pos_m;
        ticks_m    = ticks_m + 1'b1;
        // a lowered interval fires at once; zero acts as one
        if (ticks_m >= accel_every_m) begin
          accel_m     = vel_m - vel_accel_m;
          vel_accel_m = vel_m;
          ticks_m     = '0;
          accel_updates++;
        end
      end
      CMD_INDEX: begin
        rev_m       = pos_m - pos_index_m;
        pos_index_m = pos_m;
      end
      default: ;  // unused command: report the registers as they stand
    endcase
    r.position     = pos_m;
    r.velocity     = vel_m;
    r.acceleration = accel_m;
    r.rev_count    = rev_m;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [CntW-1:0] got,
                                 input logic [CntW-1:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what,
             $signed(got), $signed(want));
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each accepted request, checks each accepted result.
  // Prediction first, so a result in the same edge still pops the older entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni === 1'b1) begin
      if (req_if.valid && req_if.ready)
        readings_q.push_back(advance_decoder(req_if.command, req_if.chan_a,
                                             req_if.chan_b));
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (readings_q.size() == 0) begin
          $display("[%0t] result with no request outstanding", $realtime);
          error_count++;
        end else begin
          want = readings_q.pop_front();
          if (res_if.position !== want.position)
            report_mismatch("position", res_if.position, want.position);
          if (res_if.velocity !== want.velocity)
            report_mismatch("velocity", res_if.velocity, want.velocity);
          if (res_if.acceleration !== want.acceleration)
            report_mismatch("acceleration", res_if.acceleration, want.acceleration);
          if (res_if.rev_count !== want.rev_count)
            report_mismatch("rev_count", res_if.rev_count, want.rev_count);
          if (res_if.bad_transition !== want.bad_transition)
            report_mismatch("bad_transition", CntW'(res_if.bad_transition),
                            CntW'(want.bad_transition));
        end
      end
    end
  end

  // Watchdog: too long with nothing moving on either channel ends the run.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[%0t] watchdog: no handshake for %0d cycles, %0d readings pending",
               $realtime, quiet_cycles, readings_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly back-to-back, some short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, or a one-off long hold-off when asked.
  initial begin
    int unsigned stall_len;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_len != 0) begin
        stall_len   = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        stall_len = rx_idle_en ? pick_gap() : 0;
      end
      if (stall_len != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Valid stays high from one request to the next unless a gap is
  // drawn, so it is never dropped and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] cmd, input logic a, input logic b);
    int unsigned gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.chan_a  <= a;
    req_if.chan_b  <= b;
    if (cmd == CMD_SAMPLE) drive_phase = {b, a};
    requests_sent++;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
  endtask

  // Stop offering and wait until every request sent has its result back.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (results_seen != requests_sent) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The register is only touched with the block idle.
  task automatic write_accel_every(input logic [TickW-1:0] v);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    accel_every_m = v;  // tick counter is deliberately left as it is
  endtask

  // Encoder-like traffic: runs of single steps in one direction with reversals,
  // dwells, ticks and index pulses; a few double flips and noise requests.
  // Unused commands are not counted towards n_items.
  task automatic run_motion(input int unsigned n_items);
    int unsigned done_items;
    int unsigned roll;
    logic        dir_up;
    logic [1:0]  g;
    logic [1:0]  nxt;
    done_items = 0;
    dir_up     = 1'($urandom_range(0, 1));
    while (done_items < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 98) done_items++;
      if (roll < 68) begin
        if ($urandom_range(0, 9) == 0) dir_up = ~dir_up;
        g   = gray_of(drive_phase);
        g   = dir_up ? g + 2'd1 : g - 2'd1;
        nxt = gray_of(g);
        send_request(CMD_SAMPLE, nxt[0], nxt[1]);
      end else if (roll < 72) begin
        send_request(CMD_SAMPLE, drive_phase[0], drive_phase[1]);
      end else if (roll < 86) begin
        send_request(CMD_TICK, 1'($urandom), 1'($urandom));
      end else if (roll < 92) begin
        send_request(CMD_INDEX, 1'($urandom), 1'($urandom));
      end else if (roll < 96) begin
        nxt = ~drive_phase;
        send_request(CMD_SAMPLE, nxt[0], nxt[1]);
      end else if (roll < 98) begin
        send_request(CMD_SAMPLE, 1'($urandom), 1'($urandom));
      end else begin
        send_request(CmdUnused, 1'($urandom), 1'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every one of the 16 phase pairs once, starting from the reset phase 00,
  // mixed with ticks, index pulses and the unused command.
  task automatic test_phase_walk();
    logic [1:0] walk [16] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0,
                              2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_request(CMD_TICK, 1'b1, 1'b1);      // tick from reset, pins ignored
    send_request(CMD_INDEX, 1'b1, 1'b0);
    send_request(CmdUnused, 1'b1, 1'b1);
    foreach (walk[i]) begin
      send_request(CMD_SAMPLE, walk[i][0], walk[i][1]);
      if (i == 7) send_request(CMD_TICK, 1'b0, 1'b1);
    end
    send_request(CMD_TICK, 1'b0, 1'b0);
    send_request(CMD_INDEX, 1'b0, 1'b1);
    send_request(CmdUnused, 1'b0, 1'b0);
    send_request(CMD_TICK, 1'b1, 1'b1);
    wait_for_results();
  endtask

  // Interval of zero: updates on every tick.
  task automatic test_zero_interval();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    write_accel_every('0);
    run_motion(30);
  endtask

  // Largest interval, then lowered below the running count: the next tick
  // updates acceleration at once.
  task automatic test_lowered_interval();
    write_accel_every('1);
    while (ticks_m < 9) begin
      send_request(CMD_SAMPLE, ~drive_phase[1], drive_phase[0]);
      send_request(CMD_TICK, 1'($urandom), 1'($urandom));
      wait_for_results();
    end
    write_accel_every(TickW'(2));
    send_request(CMD_TICK, 1'b0, 1'b0);
    run_motion(20);
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // output and skid stages fill and the input stalls.
  task automatic test_output_stall();
    wait_for_results();
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_len = LongHold;
    run_motion(24);
    wait_for_results();
  endtask

  // Sender stops mid-stream until every reading is back, then carries on.
  task automatic test_sender_pause();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    run_motion(20);
    wait_for_results();
    run_motion(20);
  endtask

  // Bulk of the run: several interval settings, idling switched per chunk;
  // the first chunk runs flat out on both sides.
  task automatic test_random_motion();
    logic [TickW-1:0] setting [5] = '{TickW'(1), '1, TickW'(4), '0, TickW'(3)};
    foreach (setting[i]) begin
      write_accel_every(i == 4 ? TickW'($urandom_range(1, 15)) : setting[i]);
      tx_idle_en = (i != 0) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (i != 0) && ($urandom_range(0, 3) != 0);
      run_motion(100);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.command = CMD_SAMPLE;
    req_if.chan_a  = 1'b0;
    req_if.chan_b  = 1'b0;
    phase_m        = '0;
    pos_m          = '0;
    pos_tick_m     = '0;
    vel_m          = '0;
    vel_accel_m    = '0;
    accel_m        = '0;
    pos_index_m    = '0;
    rev_m          = '0;
    ticks_m        = '0;
    accel_every_m  = AccelEveryRst;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_phase_walk();
    test_zero_interval();
    test_lowered_interval();
    test_output_stall();
    test_sender_pause();
    test_random_motion();
    wait_for_results();

    $display("Sent %0d requests, checked %0d results, %0d double-channel flips",
             requests_sent, results_seen, flips_seen);
    $display("Intervals 0, 1, 2, 4, 15 and one random setting, %0d acceleration updates",
             accel_updates);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/qpv_pkg.sv
hdl/qpv_in_if.sv
hdl/qpv_out_if.sv
hdl/qpv_core.sv
hdl/qpv_skid.sv
hdl/quadrature_position_velocity_top.sv
sim/quadrature_position_velocity_top_test.sv
